>>> sv/bttok_pkg.sv
`default_nettype none

package bttok_pkg;

    // Offset counter width default
    localparam int OFFSET_BITS_DEFAULT = 16;

    // Width of offsets and lengths in a result
    localparam int RES_BITS = 16;

    // Configuration register indexes
    localparam logic [2:0] REG_DELIM_FIRST  = 3'd0;
    localparam logic [2:0] REG_DELIM_SECOND = 3'd1;
    localparam logic [2:0] REG_OPEN         = 3'd2;
    localparam logic [2:0] REG_CLOSE        = 3'd3;
    localparam logic [2:0] REG_ESCAPE       = 3'd4;

    // Configuration reset values
    localparam logic [7:0] DELIM_FIRST_RST  = 8'd32;
    localparam logic [7:0] DELIM_SECOND_RST = 8'd10;
    localparam logic [7:0] OPEN_RST         = 8'd40;
    localparam logic [7:0] CLOSE_RST        = 8'd41;
    localparam logic [7:0] ESCAPE_RST       = 8'd96;

    // Token kinds
    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_DELIM = 2'd1;
    localparam logic [1:0] KIND_BRACE = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_ESCAPE  = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG = 2'd2;

    // Result queue depth (room for two results per byte plus drain slack)
    localparam int RESQ_DEPTH = 4;

    typedef struct packed {
        logic [1:0]          kind;
        logic [RES_BITS-1:0] start;
        logic [RES_BITS-1:0] length;
        logic [1:0]          err;
        logic                fin;
    } tok_res_t;

endpackage

`default_nettype wire

>>> sv/bracket_text_tokenizer.sv
`default_nettype none

// Channel   Signals                                         Direction
// --------  ----------------------------------------------  ---------
// input     in_valid, in_stall, in_byte, end_of_text        byte in
// output    out_valid, out_stall, token_kind, token_start,  token out
//           token_length, error_code, final_result
// config    cfg_we, cfg_index, cfg_data                     write only
//
// One byte is taken per cycle while in_stall is low; its zero, one or two tokens are computed in
// the same cycle and written into a four-entry result queue.
// Results leave the queue one per cycle while out_stall is low, each from a registered entry.
// in_stall rises when the queue could not hold two more results.
// Reset clears the tokenizer state, empties the queue and returns the character registers to their defaults.
// out_stall only holds the queue head; the input keeps flowing until in_stall rises.

module bracket_text_tokenizer #(
    parameter int OFFSET_BITS = bttok_pkg::OFFSET_BITS_DEFAULT
) (
    input  wire                            clk,
    input  wire                            rst_n,
    // byte input
    input  wire                            in_valid,
    output logic                           in_stall,
    input  wire  [7:0]                     in_byte,
    input  wire                            end_of_text,
    // token output
    output logic                           out_valid,
    input  wire                            out_stall,
    output logic [1:0]                     token_kind,
    output logic [bttok_pkg::RES_BITS-1:0] token_start,
    output logic [bttok_pkg::RES_BITS-1:0] token_length,
    output logic [1:0]                     error_code,
    output logic                           final_result,
    // configuration
    input  wire                            cfg_we,
    input  wire  [2:0]                     cfg_index,
    input  wire  [7:0]                     cfg_data
);

    localparam int PTR_BITS = $clog2(bttok_pkg::RESQ_DEPTH);
    localparam int CNT_BITS = PTR_BITS + 1;
    localparam logic [OFFSET_BITS-1:0] POS_LIMIT = '1;
    localparam logic [CNT_BITS-1:0] STALL_LEVEL = CNT_BITS'(bttok_pkg::RESQ_DEPTH - 2);

    // Character registers
    logic [7:0] delim_first_reg;
    logic [7:0] delim_second_reg;
    logic [7:0] open_reg;
    logic [7:0] close_reg;
    logic [7:0] escape_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_first_reg  <= bttok_pkg::DELIM_FIRST_RST;
            delim_second_reg <= bttok_pkg::DELIM_SECOND_RST;
            open_reg         <= bttok_pkg::OPEN_RST;
            close_reg        <= bttok_pkg::CLOSE_RST;
            escape_reg       <= bttok_pkg::ESCAPE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bttok_pkg::REG_DELIM_FIRST:  delim_first_reg  <= cfg_data;
                bttok_pkg::REG_DELIM_SECOND: delim_second_reg <= cfg_data;
                bttok_pkg::REG_OPEN:         open_reg         <= cfg_data;
                bttok_pkg::REG_CLOSE:        close_reg        <= cfg_data;
                bttok_pkg::REG_ESCAPE:       escape_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // Tokenizer state
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] run_start_reg, run_start_next;
    logic                   in_run_reg, in_run_next;
    logic                   after_esc_reg, after_esc_next;
    logic                   error_latched_reg, error_latched_next;

    // Result queue
    bttok_pkg::tok_res_t    resq_reg [bttok_pkg::RESQ_DEPTH];
    logic [PTR_BITS-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0]    count_reg, count_next;

    logic                   in_xfer, out_xfer;
    logic                   is_delim, is_open, is_close, is_esc, is_other;
    logic                   punct_has;
    bttok_pkg::tok_res_t    punct_res, res_a, res_b;
    logic [1:0]             n_res;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0] run_from;

    function automatic bttok_pkg::tok_res_t make_res(
        input logic [1:0]             kind,
        input logic [OFFSET_BITS-1:0] start,
        input logic [OFFSET_BITS-1:0] length,
        input logic [1:0]             err
    );
        bttok_pkg::tok_res_t r;
        r.kind   = kind;
        r.start  = bttok_pkg::RES_BITS'(start);
        r.length = bttok_pkg::RES_BITS'(length);
        r.err    = err;
        r.fin    = 1'b0;
        return r;
    endfunction

    assign in_stall  = (count_reg > STALL_LEVEL);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign out_xfer  = out_valid && !out_stall;

    // Byte classes, in precedence order
    always_comb
    begin
        is_delim = (in_byte == delim_first_reg) || (in_byte == delim_second_reg);
        is_open  = !is_delim && (in_byte == open_reg);
        is_close = !is_delim && !is_open && (in_byte == close_reg);
        is_esc   = !is_delim && !is_open && !is_close && (in_byte == escape_reg);
        is_other = !is_delim && !is_open && !is_close && !is_esc;
    end

    // Token for a punctuation byte outside an escape
    always_comb
    begin
        punct_has = 1'b1;
        punct_res = make_res(bttok_pkg::KIND_TEXT, pos_reg, '0, bttok_pkg::ERR_ESCAPE);
        priority if (is_delim)
            punct_res = make_res(bttok_pkg::KIND_DELIM, pos_reg, OFFSET_BITS'(1),
                                 bttok_pkg::ERR_NONE);
        else if (is_open || is_close)
            punct_res = make_res(bttok_pkg::KIND_BRACE, pos_reg, OFFSET_BITS'(1),
                                 bttok_pkg::ERR_NONE);
        else if (!end_of_text)
            punct_has = 1'b0;
        else
            punct_has = 1'b1;
    end

    // Next state and the results of the accepted byte
    always_comb
    begin
        pos_inc            = pos_reg + OFFSET_BITS'(1);
        run_from           = in_run_reg ? run_start_reg : pos_reg;
        pos_next           = pos_reg;
        run_start_next     = run_start_reg;
        in_run_next        = in_run_reg;
        after_esc_next     = after_esc_reg;
        error_latched_next = error_latched_reg;
        res_a              = make_res(bttok_pkg::KIND_TEXT, pos_reg, '0, bttok_pkg::ERR_NONE);
        res_b              = punct_res;
        n_res              = 2'd0;

        if (in_xfer && !error_latched_reg)
        begin
            if (pos_reg == POS_LIMIT)
            begin
                res_a = make_res(bttok_pkg::KIND_TEXT, pos_reg, '0,
                                 bttok_pkg::ERR_TOO_LONG);
                n_res              = 2'd1;
                error_latched_next = 1'b1;
                in_run_next        = 1'b0;
                after_esc_next     = 1'b0;
            end
            else
            begin
                priority if (after_esc_reg)
                begin
                    after_esc_next = 1'b0;
                    n_res          = 2'd1;
                    if (!is_other)
                        res_a = make_res(bttok_pkg::KIND_TEXT, pos_reg, OFFSET_BITS'(1),
                                         bttok_pkg::ERR_NONE);
                    else
                    begin
                        res_a = make_res(bttok_pkg::KIND_TEXT, pos_reg, '0,
                                         bttok_pkg::ERR_ESCAPE);
                        error_latched_next = 1'b1;
                    end
                end
                else if (is_other)
                begin
                    in_run_next    = 1'b1;
                    run_start_next = run_from;
                    if (end_of_text)
                    begin
                        res_a = make_res(bttok_pkg::KIND_TEXT, run_from,
                                         pos_inc - run_from, bttok_pkg::ERR_NONE);
                        n_res = 2'd1;
                    end
                end
                else
                begin
                    // close an open run, then the punctuation token
                    in_run_next = 1'b0;
                    if (in_run_reg)
                    begin
                        res_a = make_res(bttok_pkg::KIND_TEXT, run_start_reg,
                                         pos_reg - run_start_reg, bttok_pkg::ERR_NONE);
                        n_res = punct_has ? 2'd2 : 2'd1;
                    end
                    else
                    begin
                        res_a = punct_res;
                        n_res = punct_has ? 2'd1 : 2'd0;
                    end
                    if (is_esc && end_of_text)
                        error_latched_next = 1'b1;
                    else if (is_esc)
                        after_esc_next = 1'b1;
                end

                if (end_of_text)
                begin
                    pos_next       = '0;
                    in_run_next    = 1'b0;
                    run_start_next = '0;
                    after_esc_next = 1'b0;
                end
                else
                    pos_next = pos_inc;
            end
        end

        res_a.fin = (n_res == 2'd1);
        res_b.fin = 1'b1;
    end

    always_comb
    begin
        count_next = count_reg + CNT_BITS'(n_res) - CNT_BITS'(out_xfer);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg           <= '0;
            run_start_reg     <= '0;
            in_run_reg        <= 1'b0;
            after_esc_reg     <= 1'b0;
            error_latched_reg <= 1'b0;
            wr_ptr_reg        <= '0;
            rd_ptr_reg        <= '0;
            count_reg         <= '0;
        end
        else
        begin
            pos_reg           <= pos_next;
            run_start_reg     <= run_start_next;
            in_run_reg        <= in_run_next;
            after_esc_reg     <= after_esc_next;
            error_latched_reg <= error_latched_next;
            wr_ptr_reg        <= wr_ptr_reg + PTR_BITS'(n_res);
            rd_ptr_reg        <= rd_ptr_reg + PTR_BITS'(out_xfer);
            count_reg         <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (n_res != 2'd0)
            resq_reg[wr_ptr_reg] <= res_a;
        if (n_res == 2'd2)
            resq_reg[wr_ptr_reg + PTR_BITS'(1)] <= res_b;
    end

    assign token_kind   = resq_reg[rd_ptr_reg].kind;
    assign token_start  = resq_reg[rd_ptr_reg].start;
    assign token_length = resq_reg[rd_ptr_reg].length;
    assign error_code   = resq_reg[rd_ptr_reg].err;
    assign final_result = resq_reg[rd_ptr_reg].fin;

    // Queue never overfills
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(bttok_pkg::RESQ_DEPTH))
        else $error("result queue overflow");

    // A latched error stays latched and produces nothing
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_latched_reg |=> error_latched_reg && (count_reg <= $past(count_reg)))
        else $error("latched error released or new result after error");

    // A pending escape never coexists with an open run
    a_esc_no_run: assert property (@(posedge clk) disable iff (!rst_n)
        after_esc_reg |-> !in_run_reg)
        else $error("escape pending with open text run");

    // Error results carry zero length
    a_err_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (error_code != bttok_pkg::ERR_NONE)) |-> (token_length == '0))
        else $error("error result with nonzero length");

endmodule

`default_nettype wire
